// File: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent checks used by the mixer RTL; they compile away under SYNTHESIS.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define MSAM_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("msam: check failed");
`define MSAM_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("msam: check failed");
`define MSAM_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("msam: check failed");
`else
`define MSAM_ASSERT(lbl, clk, rst, prop)
`define MSAM_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define MSAM_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif
`endif

// File: rtl/core/msam_pkg.sv
// ----------------------------------------------------------------------------
// Mixer package
// Sizes, codes and helpers shared by the audio mixer RTL.
// ----------------------------------------------------------------------------
package msam_pkg;

  localparam int STREAMS    = 8;
  localparam int RING_DEPTH = 4096;

  localparam int SLOT_W    = (STREAMS > 1) ? $clog2(STREAMS) : 1;
  localparam int SLOT_CNT_W = 5;
  localparam int POS_W     = $clog2(RING_DEPTH);
  localparam int RAM_DEPTH = STREAMS * RING_DEPTH;
  localparam int ADDR_W    = (RAM_DEPTH > 1) ? $clog2(RAM_DEPTH) : 1;

  localparam int SAMPLE_W = 16;
  localparam int VOL_W    = 7;
  localparam logic [VOL_W-1:0] VOL_FULL = 7'd100;

  // Shared multiplier: |sample| * volume, then product * (2^29 / 100) rounded up.
  // The reciprocal is exact for every magnitude below 2^29 / 88.
  localparam int MUL_W       = 23;
  localparam int PROD_W      = 2 * MUL_W;
  localparam int RECIP_SHIFT = 29;
  localparam longint unsigned RECIP_L = ((64'd1 << RECIP_SHIFT) + 64'd99) / 64'd100;
  localparam logic [MUL_W-1:0] RECIP = MUL_W'(RECIP_L);

  typedef enum logic [2:0] {
    CMD_OPEN   = 3'd0,
    CMD_CLOSE  = 3'd1,
    CMD_WRITE  = 3'd2,
    CMD_VOLUME = 3'd3,
    CMD_MIX    = 3'd4
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_SLOT  = 2'd1,
    ST_INACTIVE = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_MIX_CHK,
    S_MIX_MUL,
    S_MIX_DIV,
    S_MIX_ACC,
    S_DONE
  } state_t;

  function automatic logic [POS_W-1:0] pos_inc(input logic [POS_W-1:0] pos);
    pos_inc = (pos == POS_W'(RING_DEPTH - 1)) ? '0 : pos + POS_W'(1);
  endfunction

endpackage

// File: rtl/core/msam_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data, no reset.
// ----------------------------------------------------------------------------
module msam_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: rtl/core/multi_stream_audio_mixer.sv
// ----------------------------------------------------------------------------
// Multi-stream audio mixer
// Stream slots with per-slot sample rings, volume and a saturating mixdown.
// ----------------------------------------------------------------------------
// One command beat yields exactly one result beat. The block takes one command
// at a time: open, close, write and set volume pass through the execute and
// done states; a mix visits every slot in turn, and a slot that gives no
// sample is only checked and skipped. Each drained slot costs one ring read
// plus two passes through the single shared multiplier (scale by volume, then
// divide by 100 with a reciprocal), followed by the saturating add. The result
// sits in an output register, so a new command is taken while the previous
// result waits. The sample rings live in one RAM of STREAMS * RING_DEPTH
// words, one ring per slot; one ring entry per slot always stays unused to
// tell full from empty.
`include "assert_macros.svh"

module multi_stream_audio_mixer (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         cmd,
  input  logic [2:0]         slot_sel,
  input  logic signed [15:0] sample,
  input  logic [7:0]         volume_percent,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         status,
  output logic [2:0]         assigned_stream,
  output logic signed [15:0] mix_out
);
  import msam_pkg::*;

  // Sequencer state and the latched command
  state_t state, state_next;
  logic [2:0]          cmd_q;
  logic [2:0]          sid_q;
  logic [SAMPLE_W-1:0] smp_q;
  logic [7:0]          vol_q;

  // Per-slot control state
  logic [STREAMS-1:0] active;
  logic [VOL_W-1:0]   volume [STREAMS];
  logic [POS_W-1:0]   wr_pos [STREAMS];
  logic [POS_W-1:0]   rd_pos [STREAMS];

  // Mix datapath
  logic [SLOT_W-1:0]        mix_idx;
  logic signed [15:0]       acc;
  logic                     neg;
  logic [MUL_W-1:0]         mag_prod;
  logic [15:0]              quot;
  logic [MUL_W-1:0]         mul_a, mul_b;
  logic [PROD_W-1:0]        prod;
  logic signed [17:0]       scaled, sum;
  logic signed [15:0]       sum_sat;
  logic [15:0]              rd_mag;

  // Result staging and output register
  status_t    res_status;
  logic [2:0] res_assigned;
  status_t    out_status;
  logic [2:0] out_assigned;
  logic signed [15:0] out_mixed;

  // Slot selection and checks
  logic [SLOT_W-1:0] sid_slot;
  logic [SLOT_W-1:0] cur;
  logic              sid_ok;
  logic              ring_full;
  logic              mix_take;
  logic              mix_last;
  logic              any_free;
  logic [SLOT_W-1:0] free_idx;
  logic              accept;
  logic              out_free;

  // RAM port
  logic                ram_we, ram_re;
  logic [ADDR_W-1:0]   ram_base, ram_wr_addr, ram_rd_addr;
  logic signed [15:0]  ram_rd_data;

  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  // Single-command slot comes from the beat; a mix walks the counter.
  assign sid_slot  = SLOT_W'(sid_q);
  assign cur       = (state == S_EXEC) ? sid_slot : mix_idx;
  assign sid_ok    = (SLOT_CNT_W'(sid_q) < SLOT_CNT_W'(STREAMS));
  assign ring_full = (pos_inc(wr_pos[cur]) == rd_pos[cur]);
  assign mix_last  = (mix_idx == SLOT_W'(STREAMS - 1));

  // Lowest inactive slot
  always_comb begin
    any_free = 1'b0;
    free_idx = '0;
    for (int i = STREAMS - 1; i >= 0; i--) begin
      if (!active[i]) begin
        any_free = 1'b1;
        free_idx = SLOT_W'(i);
      end
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = (cmd == CMD_MIX) ? S_MIX_CHK : S_EXEC;
        end
      end
      S_EXEC: state_next = S_DONE;
      S_MIX_CHK: begin
        if (mix_take) begin
          state_next = S_MIX_MUL;
        end else if (mix_last) begin
          state_next = S_DONE;
        end
      end
      S_MIX_MUL: state_next = S_MIX_DIV;
      S_MIX_DIV: state_next = S_MIX_ACC;
      S_MIX_ACC: state_next = mix_last ? S_DONE : S_MIX_CHK;
      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_stall = (state != S_IDLE);
    mix_take = (state == S_MIX_CHK) && active[cur] && (volume[cur] != '0) &&
               (rd_pos[cur] != wr_pos[cur]);
    ram_re   = mix_take;
    ram_we   = (state == S_EXEC) && (cmd_q == CMD_WRITE) && sid_ok && active[cur] &&
               !ring_full;
    // Scale by volume first, then divide by 100 through the reciprocal.
    if (state == S_MIX_MUL) begin
      mul_a = MUL_W'(rd_mag);
      mul_b = MUL_W'(volume[cur]);
    end else begin
      mul_a = mag_prod;
      mul_b = RECIP;
    end
  end

  assign rd_mag = ram_rd_data[15] ? (~ram_rd_data + 16'd1) : ram_rd_data;
  assign prod   = PROD_W'(mul_a) * PROD_W'(mul_b);

  // Signed add with saturation to 16 bits
  assign scaled = neg ? -$signed({2'b00, quot}) : $signed({2'b00, quot});
  assign sum    = 18'(acc) + scaled;
  always_comb begin
    priority if (sum > 18'sd32767) begin
      sum_sat = 16'sh7fff;
    end else if (sum < -18'sd32768) begin
      sum_sat = 16'sh8000;
    end else begin
      sum_sat = 16'(sum);
    end
  end

  assign ram_base    = ADDR_W'(cur) * ADDR_W'(RING_DEPTH);
  assign ram_wr_addr = ram_base + ADDR_W'(wr_pos[cur]);
  assign ram_rd_addr = ram_base + ADDR_W'(rd_pos[cur]);

  msam_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (RAM_DEPTH)
  ) u_ring (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_wr_addr),
    .wr_data (smp_q),
    .rd_en   (ram_re),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      active    <= '0;
      out_valid <= 1'b0;
      for (int i = 0; i < STREAMS; i++) begin
        volume[i] <= VOL_FULL;
        wr_pos[i] <= '0;
        rd_pos[i] <= '0;
      end
    end else begin
      state <= state_next;

      // Latch the command beat and clear the result staging.
      if (accept) begin
        cmd_q        <= cmd;
        sid_q        <= slot_sel;
        smp_q        <= sample;
        vol_q        <= volume_percent;
        acc          <= '0;
        mix_idx      <= '0;
        res_status   <= ST_OK;
        res_assigned <= '0;
      end

      unique case (state)
        S_EXEC: begin
          case (cmd_q)
            CMD_OPEN: begin
              if (any_free) begin
                active[free_idx] <= 1'b1;
                volume[free_idx] <= VOL_FULL;
                wr_pos[free_idx] <= '0;
                rd_pos[free_idx] <= '0;
                res_assigned     <= 3'(free_idx);
              end else begin
                res_status <= ST_NO_SLOT;
              end
            end
            CMD_CLOSE: begin
              if (sid_ok) begin
                active[cur] <= 1'b0;
              end else begin
                res_status <= ST_INACTIVE;
              end
            end
            CMD_WRITE: begin
              priority if (!sid_ok || !active[cur]) begin
                res_status <= ST_INACTIVE;
              end else if (ring_full) begin
                res_status <= ST_FULL;
              end else begin
                wr_pos[cur] <= pos_inc(wr_pos[cur]);
              end
            end
            CMD_VOLUME: begin
              for (int i = 0; i < STREAMS; i++) begin
                volume[i] <= (vol_q > 8'd100) ? VOL_FULL : VOL_W'(vol_q);
              end
            end
            default: begin
            end
          endcase
        end
        S_MIX_CHK: begin
          // Drain one sample, or skip the slot (inactive, muted or underrun adds 0).
          if (mix_take) begin
            rd_pos[cur] <= pos_inc(rd_pos[cur]);
          end else if (!mix_last) begin
            mix_idx <= mix_idx + SLOT_W'(1);
          end
        end
        S_MIX_MUL: begin
          neg      <= ram_rd_data[15];
          mag_prod <= prod[MUL_W-1:0];
        end
        S_MIX_DIV: begin
          quot <= prod[RECIP_SHIFT +: 16];
        end
        S_MIX_ACC: begin
          acc <= sum_sat;
          if (!mix_last) begin
            mix_idx <= mix_idx + SLOT_W'(1);
          end
        end
        S_IDLE, S_DONE: begin
        end
        default: begin
        end
      endcase

      // Hand the result to the output register once it is free.
      if (state == S_DONE && out_free) begin
        out_valid    <= 1'b1;
        out_status   <= res_status;
        out_assigned <= res_assigned;
        out_mixed    <= acc;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign status          = out_status;
  assign assigned_stream = out_assigned;
  assign mix_out         = out_mixed;

  // The ring RAM never sees a read and a write in the same cycle.
  `MSAM_ASSERT(a_ram_single_access, clk, rst, !(ram_we && ram_re))
  // Ring writes come only from an executing write command.
  `MSAM_ASSERT_IMP(a_ram_we_exec, clk, rst, ram_we, state == S_EXEC && cmd_q == CMD_WRITE)
  // An accepted write never makes the ring look empty.
  `MSAM_ASSERT_NXT(a_ring_no_overrun, clk, rst, ram_we, wr_pos[sid_slot] != rd_pos[sid_slot])
  // A result beat appears only after the sequencer finishes an item.
  `MSAM_ASSERT_IMP(a_result_from_done, clk, rst, $rose(out_valid), $past(state) == S_DONE)

endmodule
